// ----- rtl/hrp_pkg.sv -----
// Package for the HTTP request parser: phase codes, field-step codes,
// status codes, sizes and character helpers. No dependencies.
package hrp_pkg;

  localparam int unsigned BufferBytes = 2048;
  localparam int unsigned PosW        = 12;
  localparam int unsigned OffW        = 11;
  localparam int unsigned LenW        = 32;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_BAD        = 2'd2
  } status_t;

  localparam logic [3:0] FS0 = 4'd0;
  localparam logic [3:0] FS1 = 4'd1;
  localparam logic [3:0] FS2 = 4'd2;
  localparam logic [3:0] FS3 = 4'd3;
  localparam logic [3:0] FS4 = 4'd4;
  localparam logic [3:0] FS5 = 4'd5;
  localparam logic [3:0] FS6 = 4'd6;
  localparam logic [3:0] FS7 = 4'd7;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSlash = 8'h2f;

  typedef struct packed {
    status_t         status;
    logic            keep_alive;
    logic [LenW-1:0] body_length;
    logic [OffW-1:0] url_offset;
    logic [PosW-1:0] url_size;
    logic [OffW-1:0] host_offset;
    logic [PosW-1:0] host_size;
  } result_t;

  function automatic logic [7:0] lower(input logic [7:0] c);
    lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'h20) || (c == 8'h09);
  endfunction

  // Lower-case literal characters, indexed by position.
  function automatic logic [7:0] get_ch(input logic [3:0] i);
    case (i)
      4'd0: get_ch = "g";
      4'd1: get_ch = "e";
      4'd2: get_ch = "t";
      default: get_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ver_ch(input logic [3:0] i);
    case (i)
      4'd0: ver_ch = "h";
      4'd1: ver_ch = "t";
      4'd2: ver_ch = "t";
      4'd3: ver_ch = "p";
      4'd4: ver_ch = "/";
      4'd5: ver_ch = "1";
      4'd6: ver_ch = ".";
      4'd7: ver_ch = "1";
      default: ver_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] http_ch(input logic [3:0] i);
    case (i)
      4'd0: http_ch = "h";
      4'd1: http_ch = "t";
      4'd2: http_ch = "t";
      4'd3: http_ch = "p";
      4'd4: http_ch = ":";
      4'd5: http_ch = "/";
      4'd6: http_ch = "/";
      default: http_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] keep_ch(input logic [3:0] i);
    case (i)
      4'd0: keep_ch = "k";
      4'd1: keep_ch = "e";
      4'd2: keep_ch = "e";
      4'd3: keep_ch = "p";
      4'd4: keep_ch = "-";
      4'd5: keep_ch = "a";
      4'd6: keep_ch = "l";
      4'd7: keep_ch = "i";
      4'd8: keep_ch = "v";
      4'd9: keep_ch = "e";
      default: keep_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] conn_ch(input logic [3:0] i);
    case (i)
      4'd0: conn_ch = "c";
      4'd1: conn_ch = "o";
      4'd2: conn_ch = "n";
      4'd3: conn_ch = "n";
      4'd4: conn_ch = "e";
      4'd5: conn_ch = "c";
      4'd6: conn_ch = "t";
      4'd7: conn_ch = "i";
      4'd8: conn_ch = "o";
      4'd9: conn_ch = "n";
      4'd10: conn_ch = ":";
      default: conn_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] clen_ch(input logic [3:0] i);
    case (i)
      4'd0: clen_ch = "c";
      4'd1: clen_ch = "o";
      4'd2: clen_ch = "n";
      4'd3: clen_ch = "t";
      4'd4: clen_ch = "e";
      4'd5: clen_ch = "n";
      4'd6: clen_ch = "t";
      4'd7: clen_ch = "-";
      4'd8: clen_ch = "l";
      4'd9: clen_ch = "e";
      4'd10: clen_ch = "n";
      4'd11: clen_ch = "g";
      4'd12: clen_ch = "t";
      4'd13: clen_ch = "h";
      4'd14: clen_ch = ":";
      default: clen_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] host_ch(input logic [3:0] i);
    case (i)
      4'd0: host_ch = "h";
      4'd1: host_ch = "o";
      4'd2: host_ch = "s";
      4'd3: host_ch = "t";
      4'd4: host_ch = ":";
      default: host_ch = 8'h00;
    endcase
  endfunction

endpackage

// ----- rtl/hrp_length_acc.sv -----
// Saturating decimal accumulate for the content length.
// Depends on hrp_pkg.
module hrp_length_acc (
  input  logic [hrp_pkg::LenW-1:0] acc,
  input  logic [3:0]               digit,
  output logic [hrp_pkg::LenW-1:0] sum
);
  import hrp_pkg::*;

  logic [LenW+4:0] wide;

  // acc*10 = acc*8 + acc*2, then add the digit; saturate on overflow.
  assign wide = ({4'd0, acc, 1'b0} << 2) + {4'd0, acc, 1'b0} + {{(LenW+1){1'b0}}, digit};
  assign sum  = (wide[LenW+4:LenW] != '0) ? '1 : wide[LenW-1:0];

endmodule

// ----- rtl/hrp_parse_step.sv -----
// Next-state and status logic for one request byte.
// Depends on hrp_pkg and hrp_length_acc.
module hrp_parse_step (
  input  logic [7:0]               b_in,
  input  hrp_pkg::phase_t          phase_i,
  input  logic [3:0]               fs_i,
  input  logic [3:0]               lp_i,
  input  logic [2:0]               hm_i,
  input  logic                     crp_i,
  input  logic [hrp_pkg::PosW-1:0] pos_i,
  input  logic [hrp_pkg::OffW-1:0] ub_i,
  input  logic [hrp_pkg::PosW-1:0] uc_i,
  input  logic [hrp_pkg::OffW-1:0] hb_i,
  input  logic [hrp_pkg::PosW-1:0] hc_i,
  input  logic [hrp_pkg::LenW-1:0] lv_i,
  input  logic [hrp_pkg::LenW-1:0] bc_i,
  input  logic                     lf_i,
  output hrp_pkg::phase_t          phase_o,
  output logic [3:0]               fs_o,
  output logic [3:0]               lp_o,
  output logic [2:0]               hm_o,
  output logic                     crp_o,
  output logic [hrp_pkg::PosW-1:0] pos_o,
  output logic [hrp_pkg::OffW-1:0] ub_o,
  output logic [hrp_pkg::PosW-1:0] uc_o,
  output logic [hrp_pkg::OffW-1:0] hb_o,
  output logic [hrp_pkg::PosW-1:0] hc_o,
  output logic [hrp_pkg::LenW-1:0] lv_o,
  output logic [hrp_pkg::LenW-1:0] bc_o,
  output logic                     lf_o,
  output hrp_pkg::status_t         st_o
);
  import hrp_pkg::*;

  logic [7:0]      lb;
  logic            bl;
  logic            dig;
  logic [LenW-1:0] acc_sum;
  logic [LenW-1:0] bc_inc;
  logic [OffW-1:0] pos_lo;
  logic [OffW-1:0] pos_p1;
  logic [3:0]      lp_p1;
  logic [2:0]      hm_n;

  assign lb     = lower(b_in);
  assign bl     = is_blank(b_in);
  assign dig    = (b_in >= 8'h30) && (b_in <= 8'h39);
  assign bc_inc = bc_i + 1'b1;
  assign pos_lo = pos_i[OffW-1:0];
  assign pos_p1 = pos_lo + 1'b1;
  assign lp_p1  = lp_i + 1'b1;

  hrp_length_acc u_acc (
    .acc   (lv_i),
    .digit (b_in[3:0] - 4'd0),
    .sum   (acc_sum)
  );

  always_comb begin
    hm_n = hm_i;
    if (hm_i[0] && !(lp_i < 4'd11 && lb == conn_ch(lp_i))) hm_n[0] = 1'b0;
    if (hm_i[1] && !(lp_i < 4'd15 && lb == clen_ch(lp_i))) hm_n[1] = 1'b0;
    if (hm_i[2] && !(lp_i < 4'd5 && lb == host_ch(lp_i)))  hm_n[2] = 1'b0;
  end

  always_comb begin
    phase_o = phase_i;
    fs_o    = fs_i;
    lp_o    = lp_i;
    hm_o    = hm_i;
    crp_o   = crp_i;
    pos_o   = pos_i;
    ub_o    = ub_i;
    uc_o    = uc_i;
    hb_o    = hb_i;
    hc_o    = hc_i;
    lv_o    = lv_i;
    bc_o    = bc_i;
    lf_o    = lf_i;
    st_o    = ST_INCOMPLETE;

    if (pos_i >= PosW'(BufferBytes)) begin
      st_o = ST_BAD;
    end else begin
      pos_o = pos_i + 1'b1;
      if (phase_i == PH_BODY) begin
        bc_o = bc_inc;
        if (bc_inc >= lv_i) st_o = ST_COMPLETE;
      end else if (crp_i) begin
        if (b_in == ChLf) begin
          crp_o = 1'b0;
          if (phase_i == PH_LINE) begin
            if (fs_i == FS6 && lp_i == 4'd8) begin
              phase_o = PH_HEAD;
              fs_o = FS0; lp_o = 4'd0; hm_o = 3'b111;
            end else begin
              st_o = ST_BAD;
            end
          end else if (fs_i == FS0 && lp_i == 4'd0) begin
            if (lv_i != '0) begin
              phase_o = PH_BODY;
              bc_o = '0;
            end else begin
              st_o = ST_COMPLETE;
            end
          end else begin
            fs_o = FS0; lp_o = 4'd0; hm_o = 3'b111;
          end
        end else begin
          st_o = ST_BAD;
        end
      end else if (b_in == ChCr) begin
        crp_o = 1'b1;
      end else if (b_in == ChLf) begin
        st_o = ST_BAD;
      end else if (phase_i == PH_LINE) begin
        case (fs_i)
          FS0: begin
            if (bl) begin
              if (lp_i != 4'd3) st_o = ST_BAD;
              else fs_o = FS1;
            end else if (lp_i < 4'd3 && lb == get_ch(lp_i)) lp_o = lp_p1;
            else st_o = ST_BAD;
          end
          FS1: begin
            if (!bl) begin
              ub_o = pos_lo;
              if (b_in == ChSlash) begin
                uc_o = 12'd1; fs_o = FS3;
              end else if (lb == "h") begin
                lp_o = 4'd1; fs_o = FS2;
              end else st_o = ST_BAD;
            end
          end
          FS2: begin
            if (!bl && lp_i < 4'd7 && lb == http_ch(lp_i)) begin
              lp_o = lp_p1;
              if (lp_p1 == 4'd7) fs_o = FS4;
            end else st_o = ST_BAD;
          end
          FS3: begin
            if (bl) fs_o = FS5;
            else uc_o = uc_i + 1'b1;
          end
          FS4: begin
            if (bl) st_o = ST_BAD;
            else if (b_in == ChSlash) begin
              ub_o = pos_lo; uc_o = 12'd1; fs_o = FS3;
            end
          end
          FS5: begin
            if (!bl) begin
              fs_o = FS6;
              if (lb == ver_ch(4'd0)) lp_o = 4'd1;
              else begin
                lp_o = 4'd0; st_o = ST_BAD;
              end
            end
          end
          FS6: begin
            if (lp_i < 4'd8 && lb == ver_ch(lp_i)) lp_o = lp_p1;
            else st_o = ST_BAD;
          end
          default: st_o = ST_BAD;
        endcase
      end else begin
        case (fs_i)
          FS0: begin
            hm_o = hm_n;
            lp_o = lp_p1;
            if (hm_n[0] && lp_p1 == 4'd11) fs_o = FS1;
            else if (hm_n[1] && lp_p1 == 4'd15) begin
              lv_o = '0; fs_o = FS3;
            end else if (hm_n[2] && lp_p1 == 4'd5) begin
              hb_o = pos_p1; hc_o = '0; fs_o = FS5;
            end else if (hm_n == 3'b000) fs_o = FS7;
          end
          FS1, FS2: begin
            if (!(fs_i == FS1 && bl)) begin
              if (fs_i == FS1) begin
                fs_o = FS2;
                if (lb == keep_ch(4'd0)) lp_o = 4'd1;
                else begin
                  lp_o = 4'd0; fs_o = FS7;
                end
              end else if (lp_i < 4'd10 && lb == keep_ch(lp_i)) begin
                lp_o = lp_p1;
                if (lp_p1 == 4'd10) begin
                  lf_o = 1'b1; fs_o = FS7;
                end
              end else fs_o = FS7;
            end
          end
          FS3, FS4: begin
            if (!(fs_i == FS3 && bl)) begin
              fs_o = FS4;
              if (dig) lv_o = acc_sum;
              else fs_o = FS7;
            end
          end
          FS5: begin
            if (bl) hb_o = pos_p1;
            else begin
              hc_o = 12'd1; fs_o = FS6;
            end
          end
          FS6: hc_o = hc_i + 1'b1;
          default: ;
        endcase
      end
    end
    if (st_o != ST_INCOMPLETE) phase_o = PH_DONE;
  end

endmodule

// ----- rtl/http_request_parser_core.sv -----
// HTTP GET request parser, one byte per word.
// Output: a result is registered when its byte is accepted and appears in the next cycle.
// Throughput: one byte per cycle unless a held result stalls in_ready; the parse state updates with each accepted byte.
// Reset: synchronous active-low rst_n clears parse state and out_valid; the result word itself is not reset.
// A finished request (complete or bad) makes the next byte start from fresh state.
// Depends on hrp_pkg, hrp_parse_step.
module http_request_parser_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic                         out_keep_alive,
  output logic [hrp_pkg::LenW-1:0]     out_body_length,
  output logic [hrp_pkg::OffW-1:0]     out_url_offset,
  output logic [hrp_pkg::PosW-1:0]     out_url_size,
  output logic [hrp_pkg::OffW-1:0]     out_host_offset,
  output logic [hrp_pkg::PosW-1:0]     out_host_size
);
  import hrp_pkg::*;

  // Parse state
  phase_t          phase_r;
  logic [3:0]      fs_r, lp_r;
  logic [2:0]      hm_r;
  logic            crp_r, lf_r;
  logic [PosW-1:0] pos_r, uc_r, hc_r;
  logic [OffW-1:0] ub_r, hb_r;
  logic [LenW-1:0] lv_r, bc_r;

  // State as seen by the step: a finished request starts afresh.
  phase_t          phase_c;
  logic [3:0]      fs_c, lp_c;
  logic [2:0]      hm_c;
  logic            crp_c, lf_c;
  logic [PosW-1:0] pos_c, uc_c, hc_c;
  logic [OffW-1:0] ub_c, hb_c;
  logic [LenW-1:0] lv_c, bc_c;

  phase_t          phase_nxt;
  logic [3:0]      fs_nxt, lp_nxt;
  logic [2:0]      hm_nxt;
  logic            crp_nxt, lf_nxt;
  logic [PosW-1:0] pos_nxt, uc_nxt, hc_nxt;
  logic [OffW-1:0] ub_nxt, hb_nxt;
  logic [LenW-1:0] lv_nxt, bc_nxt;
  status_t         st_nxt;

  result_t res_r, res_nxt;
  logic    out_valid_r;
  logic    accept;

  // Take a new word whenever the output stage is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (phase_r == PH_DONE) begin
      phase_c = PH_LINE; fs_c = FS0; lp_c = 4'd0; hm_c = 3'b111; crp_c = 1'b0;
      pos_c = '0; ub_c = '0; uc_c = '0; hb_c = '0; hc_c = '0;
      lv_c = '0; bc_c = '0; lf_c = 1'b0;
    end else begin
      phase_c = phase_r; fs_c = fs_r; lp_c = lp_r; hm_c = hm_r; crp_c = crp_r;
      pos_c = pos_r; ub_c = ub_r; uc_c = uc_r; hb_c = hb_r; hc_c = hc_r;
      lv_c = lv_r; bc_c = bc_r; lf_c = lf_r;
    end
  end

  hrp_parse_step u_step (
    .b_in (in_data_byte), .phase_i (phase_c), .fs_i (fs_c), .lp_i (lp_c),
    .hm_i (hm_c), .crp_i (crp_c), .pos_i (pos_c), .ub_i (ub_c), .uc_i (uc_c),
    .hb_i (hb_c), .hc_i (hc_c), .lv_i (lv_c), .bc_i (bc_c), .lf_i (lf_c),
    .phase_o (phase_nxt), .fs_o (fs_nxt), .lp_o (lp_nxt), .hm_o (hm_nxt),
    .crp_o (crp_nxt), .pos_o (pos_nxt), .ub_o (ub_nxt), .uc_o (uc_nxt),
    .hb_o (hb_nxt), .hc_o (hc_nxt), .lv_o (lv_nxt), .bc_o (bc_nxt),
    .lf_o (lf_nxt), .st_o (st_nxt)
  );

  // Fields are reported only with a complete request; zero otherwise.
  always_comb begin
    res_nxt = '0;
    res_nxt.status = st_nxt;
    if (st_nxt == ST_COMPLETE) begin
      res_nxt.keep_alive  = lf_nxt;
      res_nxt.body_length = lv_nxt;
      res_nxt.url_offset  = ub_nxt;
      res_nxt.url_size    = uc_nxt;
      res_nxt.host_offset = hb_nxt;
      res_nxt.host_size   = hc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE; fs_r <= FS0; lp_r <= 4'd0; hm_r <= 3'b111; crp_r <= 1'b0;
      pos_r <= '0; ub_r <= '0; uc_r <= '0; hb_r <= '0; hc_r <= '0;
      lv_r <= '0; bc_r <= '0; lf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt; fs_r <= fs_nxt; lp_r <= lp_nxt; hm_r <= hm_nxt;
        crp_r <= crp_nxt; pos_r <= pos_nxt; ub_r <= ub_nxt; uc_r <= uc_nxt;
        hb_r <= hb_nxt; hc_r <= hc_nxt; lv_r <= lv_nxt; bc_r <= bc_nxt;
        lf_r <= lf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken.
  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_keep_alive  = res_r.keep_alive;
  assign out_body_length = res_r.body_length;
  assign out_url_offset  = res_r.url_offset;
  assign out_url_size    = res_r.url_size;
  assign out_host_offset = res_r.host_offset;
  assign out_host_size   = res_r.host_size;

`ifndef NO_ASSERTIONS
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_nxt == PH_DONE) |-> st_nxt != ST_INCOMPLETE)
    else $error("finished phase without a final status");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosW'(BufferBytes))
    else $error("byte position beyond buffer");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(res_r) && out_valid)
    else $error("result word changed while stalled");
`endif

endmodule
